// ----- hdl/cl20_mva_pkg.sv -----
// Package for the Cl(2,0) multivector operation unit: word types, opcodes,
// component widths and the saturation helpers. Depends on nothing.
`default_nettype none

package cl20_mva_pkg;

  localparam int unsigned CompW  = 16;
  localparam int unsigned FracW  = 12;
  localparam int unsigned ProdW  = 2 * CompW;
  localparam int unsigned SumW   = ProdW + 2;
  localparam int unsigned TolW   = 15;
  localparam int unsigned FuncW  = 4;
  localparam int unsigned MaskW  = 3;
  localparam int unsigned NumCmp = 4;

  localparam int unsigned GradeScalar = 0;
  localparam int unsigned GradeVector = 1;
  localparam int unsigned GradeBivec  = 2;

  typedef logic signed [CompW-1:0] comp_t;
  typedef logic signed [ProdW-1:0] prod_t;
  typedef logic signed [SumW-1:0]  sum_t;
  typedef logic [TolW-1:0]         tol_t;

  typedef enum logic [FuncW-1:0] {
    FUNC_ADD   = 4'd0,
    FUNC_SUB   = 4'd1,
    FUNC_NEG   = 4'd2,
    FUNC_SCALE = 4'd3,
    FUNC_GP    = 4'd4,
    FUNC_REV   = 4'd5,
    FUNC_INVOL = 4'd6,
    FUNC_CONJ  = 4'd7,
    FUNC_PROJ  = 4'd8,
    FUNC_DOT   = 4'd9,
    FUNC_WEDGE = 4'd10,
    FUNC_NORM2 = 4'd11,
    FUNC_NEAR  = 4'd12
  } func_e;

  typedef struct packed {
    logic [FuncW-1:0] func;
    comp_t            a_scalar;
    comp_t            a_e1;
    comp_t            a_e2;
    comp_t            a_e12;
    comp_t            b_scalar;
    comp_t            b_e1;
    comp_t            b_e2;
    comp_t            b_e12;
    comp_t            factor;
    logic [MaskW-1:0] grade_sel;
  } in_t;

  typedef struct packed {
    comp_t r_scalar;
    comp_t r_e1;
    comp_t r_e2;
    comp_t r_e12;
    logic  near_flag;
    logic  overflow;
  } out_t;

  typedef struct packed {
    comp_t value;
    logic  ovf;
  } sat_t;

  localparam sum_t CompMax = sum_t'((64'sd1 <<< (CompW - 1)) - 64'sd1);
  localparam sum_t CompMin = sum_t'(-(64'sd1 <<< (CompW - 1)));

  // Clamps a wide value to the component range and reports whether it clamped.
  function automatic sat_t sat_comp(sum_t v);
    sat_t res;
    if (v > CompMax) begin
      res.value = comp_t'(CompMax);
      res.ovf   = 1'b1;
    end else if (v < CompMin) begin
      res.value = comp_t'(CompMin);
      res.ovf   = 1'b1;
    end else begin
      res.value = v[CompW-1:0];
      res.ovf   = 1'b0;
    end
    return res;
  endfunction

  // Drops the fraction bits of a product sum, rounding towards minus infinity.
  function automatic sat_t sat_prod(sum_t s);
    return sat_comp(s >>> FracW);
  endfunction

  function automatic sum_t ext_comp(comp_t c);
    return {{(SumW - CompW){c[CompW-1]}}, c};
  endfunction

  function automatic sum_t ext_prod(prod_t p);
    return {{(SumW - ProdW){p[ProdW-1]}}, p};
  endfunction

endpackage

`default_nettype wire

// ----- hdl/cl20_mva_datapath.sv -----
// Combinational arithmetic of the multivector unit: one input word in, one
// result word out. Depends on cl20_mva_pkg.
`default_nettype none

module cl20_mva_datapath (
  input  wire cl20_mva_pkg::in_t  in_i,
  input  wire cl20_mva_pkg::tol_t tol_i,
  output cl20_mva_pkg::out_t      res_o
);

  cl20_mva_pkg::comp_t av [cl20_mva_pkg::NumCmp];
  cl20_mva_pkg::comp_t bv [cl20_mva_pkg::NumCmp];
  cl20_mva_pkg::comp_t bm [cl20_mva_pkg::NumCmp];
  cl20_mva_pkg::prod_t p  [cl20_mva_pkg::NumCmp][cl20_mva_pkg::NumCmp];
  cl20_mva_pkg::sat_t  r  [cl20_mva_pkg::NumCmp];
  logic signed [cl20_mva_pkg::CompW:0] diff [cl20_mva_pkg::NumCmp];
  logic [cl20_mva_pkg::CompW:0]        mag  [cl20_mva_pkg::NumCmp];
  logic [cl20_mva_pkg::NumCmp-1:0]     far;

  assign av[0] = in_i.a_scalar;
  assign av[1] = in_i.a_e1;
  assign av[2] = in_i.a_e2;
  assign av[3] = in_i.a_e12;
  assign bv[0] = in_i.b_scalar;
  assign bv[1] = in_i.b_e1;
  assign bv[2] = in_i.b_e2;
  assign bv[3] = in_i.b_e12;

  // The product array is shared: norm squared multiplies a by itself and
  // scale puts the factor in the scalar column.
  always_comb begin
    for (int j = 0; j < cl20_mva_pkg::NumCmp; j++) begin
      bm[j] = (in_i.func == cl20_mva_pkg::FUNC_NORM2) ? av[j] : bv[j];
    end
    if (in_i.func == cl20_mva_pkg::FUNC_SCALE) begin
      bm[0] = in_i.factor;
    end
  end

  always_comb begin
    for (int i = 0; i < cl20_mva_pkg::NumCmp; i++) begin
      for (int j = 0; j < cl20_mva_pkg::NumCmp; j++) begin
        p[i][j] = cl20_mva_pkg::prod_t'(av[i]) * cl20_mva_pkg::prod_t'(bm[j]);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < cl20_mva_pkg::NumCmp; i++) begin
      diff[i] = {av[i][cl20_mva_pkg::CompW-1], av[i]} - {bv[i][cl20_mva_pkg::CompW-1], bv[i]};
      mag[i]  = diff[i][cl20_mva_pkg::CompW] ? (cl20_mva_pkg::CompW+1)'(-diff[i])
                                             : diff[i];
      far[i]  = mag[i] > {{(cl20_mva_pkg::CompW + 1 - cl20_mva_pkg::TolW){1'b0}}, tol_i};
    end
  end

  always_comb begin
    for (int i = 0; i < cl20_mva_pkg::NumCmp; i++) begin
      r[i] = '0;
    end
    res_o = '0;
    case (in_i.func)
      cl20_mva_pkg::FUNC_ADD: begin
        for (int i = 0; i < cl20_mva_pkg::NumCmp; i++) begin
          r[i] = cl20_mva_pkg::sat_comp(cl20_mva_pkg::ext_comp(av[i])
                                        + cl20_mva_pkg::ext_comp(bv[i]));
        end
      end
      cl20_mva_pkg::FUNC_SUB: begin
        for (int i = 0; i < cl20_mva_pkg::NumCmp; i++) begin
          r[i] = cl20_mva_pkg::sat_comp(cl20_mva_pkg::ext_comp(av[i])
                                        - cl20_mva_pkg::ext_comp(bv[i]));
        end
      end
      cl20_mva_pkg::FUNC_NEG: begin
        for (int i = 0; i < cl20_mva_pkg::NumCmp; i++) begin
          r[i] = cl20_mva_pkg::sat_comp(-cl20_mva_pkg::ext_comp(av[i]));
        end
      end
      cl20_mva_pkg::FUNC_SCALE: begin
        for (int i = 0; i < cl20_mva_pkg::NumCmp; i++) begin
          r[i] = cl20_mva_pkg::sat_prod(cl20_mva_pkg::ext_prod(p[i][0]));
        end
      end
      cl20_mva_pkg::FUNC_GP: begin
        r[0] = cl20_mva_pkg::sat_prod(cl20_mva_pkg::ext_prod(p[0][0])
               + cl20_mva_pkg::ext_prod(p[1][1]) + cl20_mva_pkg::ext_prod(p[2][2])
               - cl20_mva_pkg::ext_prod(p[3][3]));
        r[1] = cl20_mva_pkg::sat_prod(cl20_mva_pkg::ext_prod(p[0][1])
               + cl20_mva_pkg::ext_prod(p[1][0]) - cl20_mva_pkg::ext_prod(p[2][3])
               + cl20_mva_pkg::ext_prod(p[3][2]));
        r[2] = cl20_mva_pkg::sat_prod(cl20_mva_pkg::ext_prod(p[0][2])
               + cl20_mva_pkg::ext_prod(p[2][0]) + cl20_mva_pkg::ext_prod(p[1][3])
               - cl20_mva_pkg::ext_prod(p[3][1]));
        r[3] = cl20_mva_pkg::sat_prod(cl20_mva_pkg::ext_prod(p[0][3])
               + cl20_mva_pkg::ext_prod(p[3][0]) + cl20_mva_pkg::ext_prod(p[1][2])
               - cl20_mva_pkg::ext_prod(p[2][1]));
      end
      cl20_mva_pkg::FUNC_REV: begin
        r[0].value = av[0];
        r[1].value = av[1];
        r[2].value = av[2];
        r[3]       = cl20_mva_pkg::sat_comp(-cl20_mva_pkg::ext_comp(av[3]));
      end
      cl20_mva_pkg::FUNC_INVOL: begin
        r[0].value = av[0];
        r[1]       = cl20_mva_pkg::sat_comp(-cl20_mva_pkg::ext_comp(av[1]));
        r[2]       = cl20_mva_pkg::sat_comp(-cl20_mva_pkg::ext_comp(av[2]));
        r[3].value = av[3];
      end
      cl20_mva_pkg::FUNC_CONJ: begin
        r[0].value = av[0];
        for (int i = 1; i < cl20_mva_pkg::NumCmp; i++) begin
          r[i] = cl20_mva_pkg::sat_comp(-cl20_mva_pkg::ext_comp(av[i]));
        end
      end
      cl20_mva_pkg::FUNC_PROJ: begin
        if (in_i.grade_sel[cl20_mva_pkg::GradeScalar]) begin
          r[0].value = av[0];
        end
        if (in_i.grade_sel[cl20_mva_pkg::GradeVector]) begin
          r[1].value = av[1];
          r[2].value = av[2];
        end
        if (in_i.grade_sel[cl20_mva_pkg::GradeBivec]) begin
          r[3].value = av[3];
        end
      end
      cl20_mva_pkg::FUNC_DOT, cl20_mva_pkg::FUNC_NORM2: begin
        r[0] = cl20_mva_pkg::sat_prod(cl20_mva_pkg::ext_prod(p[1][1])
               + cl20_mva_pkg::ext_prod(p[2][2]));
      end
      cl20_mva_pkg::FUNC_WEDGE: begin
        r[0] = cl20_mva_pkg::sat_prod(cl20_mva_pkg::ext_prod(p[1][2])
               - cl20_mva_pkg::ext_prod(p[2][1]));
      end
      cl20_mva_pkg::FUNC_NEAR: begin
        res_o.near_flag = ~|far;
      end
      default: begin
      end
    endcase
    res_o.r_scalar = r[0].value;
    res_o.r_e1     = r[1].value;
    res_o.r_e2     = r[2].value;
    res_o.r_e12    = r[3].value;
    res_o.overflow = r[0].ovf | r[1].ovf | r[2].ovf | r[3].ovf;
  end

endmodule

`default_nettype wire

// ----- hdl/cl20_multivector_alu_unit.sv -----
// Top level of the Cl(2,0) multivector operation unit: input register,
// arithmetic and result register. Depends on cl20_mva_pkg and cl20_mva_datapath.
//
// Usage: an operation word (opcode, operands a and b, scale factor, grade
// mask) enters on the in channel when in_valid_i and in_ready_o are both high.
// One result word per operation leaves on the out channel, in order, when
// out_valid_o and out_ready_i are both high.
// A word accepted on the in channel sits in the input register, and once the
// result register can take it, its result is registered there and out_valid_o
// rises with it; all arithmetic lies between the two registers.
// Throughput is one word per cycle when out_ready_i holds high; the two
// registers form a two-deep pipe, so a new word is taken while a finished
// result still waits at the output. When the receiver stalls the result
// holds, the pipe fills and in_ready_o falls once both registers are
// occupied; it rises again as soon as the result is taken.
// The near tolerance register is written through cfg_we_i and cfg_wdata_i
// only while the unit is idle, a rule for the user that the unit does not
// enforce. Reset empties both registers and clears the tolerance to zero.
`default_nettype none

module cl20_multivector_alu_unit (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          in_valid_i,
  output logic                         in_ready_o,
  input  wire cl20_mva_pkg::in_t       in_data_i,
  output logic                         out_valid_o,
  input  wire                          out_ready_i,
  output cl20_mva_pkg::out_t           out_data_o,
  input  wire                          cfg_we_i,
  input  wire [cl20_mva_pkg::TolW-1:0] cfg_wdata_i
);

  cl20_mva_pkg::in_t  in_q;
  cl20_mva_pkg::in_t  in_d;
  logic               in_valid_q;
  logic               in_valid_d;
  cl20_mva_pkg::out_t res_q;
  cl20_mva_pkg::out_t res_d;
  cl20_mva_pkg::out_t res_comb;
  logic               res_valid_q;
  logic               res_valid_d;
  cl20_mva_pkg::tol_t tol_q;
  cl20_mva_pkg::tol_t tol_d;
  logic               res_ready;
  logic               in_ready;

  assign res_ready = ~res_valid_q | out_ready_i;
  assign in_ready  = ~in_valid_q | res_ready;

  cl20_mva_datapath u_datapath (
    .in_i  (in_q),
    .tol_i (tol_q),
    .res_o (res_comb)
  );

  always_comb begin
    in_d        = in_ready ? in_data_i : in_q;
    in_valid_d  = in_ready ? in_valid_i : in_valid_q;
    res_d       = res_ready ? res_comb : res_q;
    res_valid_d = res_ready ? in_valid_q : res_valid_q;
    tol_d       = cfg_we_i ? cfg_wdata_i : tol_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
      tol_q       <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      res_valid_q <= res_valid_d;
      tol_q       <= tol_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q  <= in_d;
    res_q <= res_d;
  end

  assign in_ready_o  = in_ready;
  assign out_valid_o = res_valid_q;
  assign out_data_o  = res_q;

endmodule

`default_nettype wire

// ----- bench/cl20_multivector_alu_unit_test.sv -----
// Self-checking testbench for cl20_multivector_alu_unit: a directed table, then random
// words under several near tolerances, with random gaps and stalls on both channels.
// Depends on cl20_mva_pkg and the unit itself.
`timescale 1ns / 100ps

module cl20_multivector_alu_unit_test;

  typedef cl20_mva_pkg::in_t   in_t;
  typedef cl20_mva_pkg::out_t  out_t;
  typedef cl20_mva_pkg::comp_t comp_t;
  typedef cl20_mva_pkg::tol_t  tol_t;

  localparam longint CompHi = (longint'(1) <<< (cl20_mva_pkg::CompW - 1)) - 1;
  localparam longint CompLo = -(longint'(1) <<< (cl20_mva_pkg::CompW - 1));
  localparam int PhaseWords = 258;

  typedef struct {
    in_t  word;
    bit   typed;
    out_t result;
  } mv_case_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_data_o;
  logic cfg_we_i = 1'b0;
  tol_t cfg_wdata_i = '0;

  out_t mv_result_q[$];
  mv_case_t directed_tab[$];
  tol_t active_tol = '0;
  bit burst_mode = 1'b0;
  int fault_cnt = 0;

  cl20_multivector_alu_unit i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #2_000_000;
    $display("[cl20_multivector_alu_unit] ERROR");
    $finish;
  end

  function automatic comp_t clamp_comp(longint v, inout bit ovf);
    if (v > CompHi) begin
      ovf = 1'b1;
      return comp_t'(CompHi);
    end
    if (v < CompLo) begin
      ovf = 1'b1;
      return comp_t'(CompLo);
    end
    return comp_t'(v);
  endfunction

  function automatic comp_t scaled_comp(longint s, inout bit ovf);
    return clamp_comp(s >>> cl20_mva_pkg::FracW, ovf);
  endfunction

  function automatic out_t predict_mv_op(in_t w, tol_t tol);
    longint a[4];
    longint b[4];
    longint f;
    longint d;
    comp_t r[4];
    bit ovf;
    bit near;
    int i;
    out_t res;
    ovf = 1'b0;
    near = 1'b0;
    for (i = 0; i < 4; i++) r[i] = '0;
    a[0] = w.a_scalar; a[1] = w.a_e1; a[2] = w.a_e2; a[3] = w.a_e12;
    b[0] = w.b_scalar; b[1] = w.b_e1; b[2] = w.b_e2; b[3] = w.b_e12;
    f = w.factor;
    case (w.func)
      cl20_mva_pkg::FUNC_ADD:
        for (i = 0; i < 4; i++) r[i] = clamp_comp(a[i] + b[i], ovf);
      cl20_mva_pkg::FUNC_SUB:
        for (i = 0; i < 4; i++) r[i] = clamp_comp(a[i] - b[i], ovf);
      cl20_mva_pkg::FUNC_NEG:
        for (i = 0; i < 4; i++) r[i] = clamp_comp(-a[i], ovf);
      cl20_mva_pkg::FUNC_SCALE:
        for (i = 0; i < 4; i++) r[i] = scaled_comp(a[i] * f, ovf);
      cl20_mva_pkg::FUNC_GP: begin
        r[0] = scaled_comp(a[0] * b[0] + a[1] * b[1] + a[2] * b[2] - a[3] * b[3], ovf);
        r[1] = scaled_comp(a[0] * b[1] + a[1] * b[0] - a[2] * b[3] + a[3] * b[2], ovf);
        r[2] = scaled_comp(a[0] * b[2] + a[2] * b[0] + a[1] * b[3] - a[3] * b[1], ovf);
        r[3] = scaled_comp(a[0] * b[3] + a[3] * b[0] + a[1] * b[2] - a[2] * b[1], ovf);
      end
      cl20_mva_pkg::FUNC_REV: begin
        for (i = 0; i < 3; i++) r[i] = clamp_comp(a[i], ovf);
        r[3] = clamp_comp(-a[3], ovf);
      end
      cl20_mva_pkg::FUNC_INVOL: begin
        r[0] = clamp_comp(a[0], ovf);
        r[1] = clamp_comp(-a[1], ovf);
        r[2] = clamp_comp(-a[2], ovf);
        r[3] = clamp_comp(a[3], ovf);
      end
      cl20_mva_pkg::FUNC_CONJ: begin
        r[0] = clamp_comp(a[0], ovf);
        for (i = 1; i < 4; i++) r[i] = clamp_comp(-a[i], ovf);
      end
      cl20_mva_pkg::FUNC_PROJ: begin
        if (w.grade_sel[cl20_mva_pkg::GradeScalar]) r[0] = clamp_comp(a[0], ovf);
        if (w.grade_sel[cl20_mva_pkg::GradeVector]) begin
          r[1] = clamp_comp(a[1], ovf);
          r[2] = clamp_comp(a[2], ovf);
        end
        if (w.grade_sel[cl20_mva_pkg::GradeBivec]) r[3] = clamp_comp(a[3], ovf);
      end
      cl20_mva_pkg::FUNC_DOT: r[0] = scaled_comp(a[1] * b[1] + a[2] * b[2], ovf);
      cl20_mva_pkg::FUNC_WEDGE: r[0] = scaled_comp(a[1] * b[2] - a[2] * b[1], ovf);
      cl20_mva_pkg::FUNC_NORM2: r[0] = scaled_comp(a[1] * a[1] + a[2] * a[2], ovf);
      cl20_mva_pkg::FUNC_NEAR: begin
        near = 1'b1;
        for (i = 0; i < 4; i++) begin
          d = a[i] - b[i];
          if (d < 0) d = -d;
          if (d > longint'(tol)) near = 1'b0;
        end
      end
      default: ;
    endcase
    res.r_scalar = r[0];
    res.r_e1 = r[1];
    res.r_e2 = r[2];
    res.r_e12 = r[3];
    res.near_flag = near;
    res.overflow = ovf;
    return res;
  endfunction

  function automatic in_t mk_word(logic [cl20_mva_pkg::FuncW-1:0] fn,
                                  int a0, int a1, int a2, int a3,
                                  int b0, int b1, int b2, int b3, int fac, int msk);
    in_t w;
    w.func = fn;
    w.a_scalar = comp_t'(a0); w.a_e1 = comp_t'(a1); w.a_e2 = comp_t'(a2);
    w.a_e12 = comp_t'(a3);
    w.b_scalar = comp_t'(b0); w.b_e1 = comp_t'(b1); w.b_e2 = comp_t'(b2);
    w.b_e12 = comp_t'(b3);
    w.factor = comp_t'(fac);
    w.grade_sel = cl20_mva_pkg::MaskW'(msk);
    return w;
  endfunction

  function automatic out_t mk_result(int s, int e1, int e2, int e12, bit nr, bit ov);
    out_t r;
    r.r_scalar = comp_t'(s); r.r_e1 = comp_t'(e1); r.r_e2 = comp_t'(e2);
    r.r_e12 = comp_t'(e12);
    r.near_flag = nr;
    r.overflow = ov;
    return r;
  endfunction

  function automatic comp_t rand_comp();
    case ($urandom_range(0, 9))
      0: return comp_t'(CompLo);
      1: return comp_t'(CompHi);
      2: return comp_t'(int'($urandom_range(0, 2)) - 1);
      3, 4, 5: return comp_t'(int'($urandom_range(0, 16384)) - 8192);
      default: return comp_t'($urandom);
    endcase
  endfunction

  function automatic comp_t near_partner(comp_t a, int t);
    return comp_t'(longint'(a) + longint'($urandom_range(0, 2 * t + 4)) - (t + 2));
  endfunction

  function automatic in_t random_word(tol_t tol);
    in_t w;
    if ($urandom_range(0, 99) < 3) w.func = cl20_mva_pkg::FuncW'($urandom_range(13, 15));
    else w.func = cl20_mva_pkg::FuncW'($urandom_range(0, 12));
    w.a_scalar = rand_comp(); w.a_e1 = rand_comp(); w.a_e2 = rand_comp();
    w.a_e12 = rand_comp();
    w.b_scalar = rand_comp(); w.b_e1 = rand_comp(); w.b_e2 = rand_comp();
    w.b_e12 = rand_comp();
    w.factor = rand_comp();
    w.grade_sel = cl20_mva_pkg::MaskW'($urandom_range(0, 7));
    if (w.func == cl20_mva_pkg::FUNC_NEAR && $urandom_range(0, 3) != 0) begin
      w.b_scalar = near_partner(w.a_scalar, tol);
      w.b_e1 = near_partner(w.a_e1, tol);
      w.b_e2 = near_partner(w.a_e2, tol);
      w.b_e12 = near_partner(w.a_e12, tol);
    end
    return w;
  endfunction

  task automatic offer_word(in_t w, out_t exp);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    mv_result_q.push_back(exp);
  endtask

  task automatic settle_pipe();
    in_valid_i <= 1'b0;
    while (mv_result_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_tolerance(tol_t v);
    settle_pipe();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    active_tol = v;
  endtask

  task automatic report_field(string fld, longint e, longint a);
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, fld, e, a);
  endtask

  initial begin
    mv_case_t row;
    out_t exp;
    in_t w;
    tol_t tol_plan[6];
    tol_plan = '{15'h7fff, 15'd1, 15'd0, 15'd200, 15'd4096, 15'd0};
    tol_plan[5] = cl20_mva_pkg::TolW'($urandom);

    directed_tab.push_back('{mk_word(cl20_mva_pkg::FUNC_NEAR, 4096, -4096, 1, 0,
                                     4096, -4096, 1, 0, 0, 0),
                             1'b1, mk_result(0, 0, 0, 0, 1'b1, 1'b0)});
    directed_tab.push_back('{mk_word(cl20_mva_pkg::FUNC_NEAR, 4096, -4096, 1, 0,
                                     4096, -4096, 2, 0, 0, 0),
                             1'b1, mk_result(0, 0, 0, 0, 1'b0, 1'b0)});
    directed_tab.push_back('{mk_word(cl20_mva_pkg::FUNC_NEAR, 32767, -32768, 32767, -32768,
                                     -32768, 32767, -32768, 32767, 0, 7),
                             1'b1, mk_result(0, 0, 0, 0, 1'b0, 1'b0)});
    directed_tab.push_back('{mk_word(cl20_mva_pkg::FUNC_ADD, 32767, -32768, 1, 0,
                                     1, -1, -1, 0, 0, 0),
                             1'b1, mk_result(32767, -32768, 0, 0, 1'b0, 1'b1)});
    directed_tab.push_back('{mk_word(cl20_mva_pkg::FUNC_SUB, -32768, 32767, 0, 0,
                                     1, -1, -32768, 0, 0, 0),
                             1'b1, mk_result(-32768, 32767, 32767, 0, 1'b0, 1'b1)});
    directed_tab.push_back('{mk_word(cl20_mva_pkg::FUNC_NEG, -32768, -32768, -32768, -32768,
                                     0, 0, 0, 0, 0, 0),
                             1'b1, mk_result(32767, 32767, 32767, 32767, 1'b0, 1'b1)});
    directed_tab.push_back('{mk_word(cl20_mva_pkg::FUNC_NEG, 0, 1, -1, 32767,
                                     5, 5, 5, 5, 0, 0),
                             1'b1, mk_result(0, -1, 1, -32767, 1'b0, 1'b0)});
    directed_tab.push_back('{mk_word(cl20_mva_pkg::FUNC_SCALE, -1, -1, -1, -1,
                                     0, 0, 0, 0, 1, 0),
                             1'b1, mk_result(-1, -1, -1, -1, 1'b0, 1'b0)});
    directed_tab.push_back('{mk_word(cl20_mva_pkg::FUNC_SCALE, -32768, -32768, -32768, -32768,
                                     0, 0, 0, 0, -32768, 0),
                             1'b1, mk_result(32767, 32767, 32767, 32767, 1'b0, 1'b1)});
    directed_tab.push_back('{mk_word(cl20_mva_pkg::FUNC_SCALE, 4096, -4096, 32767, -32768,
                                     0, 0, 0, 0, 4096, 0), 1'b0, '0});
    directed_tab.push_back('{mk_word(cl20_mva_pkg::FUNC_GP, 0, 4096, 0, 0,
                                     0, 0, 4096, 0, 32767, 7), 1'b0, '0});
    directed_tab.push_back('{mk_word(cl20_mva_pkg::FUNC_GP, 0, 0, 0, 4096,
                                     0, 0, 0, 4096, 0, 0), 1'b0, '0});
    directed_tab.push_back('{mk_word(cl20_mva_pkg::FUNC_GP, -32768, -32768, -32768, -32768,
                                     -32768, -32768, -32768, -32768, 0, 0), 1'b0, '0});
    directed_tab.push_back('{mk_word(cl20_mva_pkg::FUNC_REV, 1, 2, 3, -32768,
                                     0, 0, 0, 0, 0, 0), 1'b0, '0});
    directed_tab.push_back('{mk_word(cl20_mva_pkg::FUNC_INVOL, 1, -32768, 32767, 5,
                                     0, 0, 0, 0, 0, 0), 1'b0, '0});
    directed_tab.push_back('{mk_word(cl20_mva_pkg::FUNC_CONJ, -32768, -32768, -32768, -32768,
                                     0, 0, 0, 0, 0, 0), 1'b0, '0});
    directed_tab.push_back('{mk_word(cl20_mva_pkg::FUNC_PROJ, 1, 2, 3, 4,
                                     0, 0, 0, 0, 0, 0), 1'b0, '0});
    directed_tab.push_back('{mk_word(cl20_mva_pkg::FUNC_PROJ, 1, 2, 3, 4,
                                     0, 0, 0, 0, 0, 7), 1'b0, '0});
    directed_tab.push_back('{mk_word(cl20_mva_pkg::FUNC_PROJ, 1, 2, 3, 4,
                                     0, 0, 0, 0, 0, 5), 1'b0, '0});
    directed_tab.push_back('{mk_word(cl20_mva_pkg::FUNC_DOT, 0, 32767, 32767, 0,
                                     0, 32767, 32767, 0, 0, 0), 1'b0, '0});
    directed_tab.push_back('{mk_word(cl20_mva_pkg::FUNC_WEDGE, 0, -32768, 0, 0,
                                     0, 0, 32767, 0, 0, 0), 1'b0, '0});
    directed_tab.push_back('{mk_word(cl20_mva_pkg::FUNC_NORM2, 0, -32768, -32768, 0,
                                     0, 0, 0, 0, 0, 0), 1'b0, '0});
    directed_tab.push_back('{mk_word(4'd13, 32767, 32767, 32767, 32767,
                                     32767, 32767, 32767, 32767, 32767, 7),
                             1'b1, mk_result(0, 0, 0, 0, 1'b0, 1'b0)});
    directed_tab.push_back('{mk_word(4'd15, -32768, -32768, -32768, -32768,
                                     -32768, -32768, -32768, -32768, -32768, 7),
                             1'b1, mk_result(0, 0, 0, 0, 1'b0, 1'b0)});

    while (!rst_ni) @(posedge clk_i);
    @(posedge clk_i);

    foreach (directed_tab[k]) begin
      row = directed_tab[k];
      exp = row.typed ? row.result : predict_mv_op(row.word, active_tol);
      offer_word(row.word, exp);
    end

    for (int p = 0; p < 6; p++) begin
      set_tolerance(tol_plan[p]);
      for (int k = 0; k < PhaseWords; k++) begin
        burst_mode = (k < 40);
        w = random_word(active_tol);
        offer_word(w, predict_mv_op(w, active_tol));
      end
      burst_mode = 1'b0;
    end

    settle_pipe();
    if (fault_cnt == 0) begin
      $display("[cl20_multivector_alu_unit] OK");
    end else begin
      $display("[cl20_multivector_alu_unit] ERROR");
    end
    $finish;
  end

  initial begin
    int stall;
    int taken;
    out_t got;
    out_t exp;
    taken = 0;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      stall = burst_mode ? 0 : $urandom_range(0, 10);
      if (taken == 300) stall = 80;
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      got = out_data_o;
      taken++;
      if (mv_result_q.size() == 0) begin
        fault_cnt++;
        $display("%0t: result word with none expected, expected nothing, got %h",
                 $time, got);
      end else begin
        exp = mv_result_q.pop_front();
        if (got !== exp) begin
          fault_cnt++;
          if (got.r_scalar !== exp.r_scalar) report_field("r_scalar", exp.r_scalar, got.r_scalar);
          if (got.r_e1 !== exp.r_e1) report_field("r_e1", exp.r_e1, got.r_e1);
          if (got.r_e2 !== exp.r_e2) report_field("r_e2", exp.r_e2, got.r_e2);
          if (got.r_e12 !== exp.r_e12) report_field("r_e12", exp.r_e12, got.r_e12);
          if (got.near_flag !== exp.near_flag)
            report_field("near_flag", exp.near_flag, got.near_flag);
          if (got.overflow !== exp.overflow) report_field("overflow", exp.overflow, got.overflow);
        end
      end
    end
  end

endmodule

// ----- files.f -----
hdl/cl20_mva_pkg.sv
hdl/cl20_mva_datapath.sv
hdl/cl20_multivector_alu_unit.sv
bench/cl20_multivector_alu_unit_test.sv
